// ===== rtl/core/ips_pkg.sv =====
// ----------------------------------------------------------------------------
// ips_pkg
// Shared types, constants and tables for the interrupt priority selector.
// ----------------------------------------------------------------------------
package ips_pkg;

	// number of interrupt sources and derived widths
	localparam int NUM_SRC   = 15;
	localparam int SRC_W     = 4;
	localparam int PRIO_W    = 4;
	localparam int CODE_W    = 12;
	localparam int REG_W     = 16;
	localparam int SR_W      = 32;
	localparam int CFG_IDX_W = 2;

	// status word fields
	localparam int SR_BLOCK_BIT = 28;
	localparam int SR_MASK_LO   = 4;

	// write masks for the stored-only registers
	localparam logic [REG_W-1:0] CTRL_MASK   = 16'hC380;
	localparam logic [REG_W-1:0] PRIO_B_MASK = 16'hFFF0;

	// register indexes on the config port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CTRL   = 2'd0,
		REG_PRIO_A = 2'd1,
		REG_PRIO_B = 2'd2,
		REG_PRIO_C = 2'd3
	} reg_idx_t;

	// source group boundaries
	localparam logic [SRC_W-1:0] SRC_EXT0   = 4'd0;
	localparam logic [SRC_W-1:0] SRC_EXT1   = 4'd1;
	localparam logic [SRC_W-1:0] SRC_EXT2   = 4'd2;
	localparam logic [SRC_W-1:0] SRC_TMR0   = 4'd3;
	localparam logic [SRC_W-1:0] SRC_TMR1   = 4'd4;
	localparam logic [SRC_W-1:0] SRC_TMR2   = 4'd5;
	localparam logic [SRC_W-1:0] SRC_DMA_LO = 4'd6;
	localparam logic [SRC_W-1:0] SRC_DMA_HI = 4'd10;
	localparam logic [SRC_W-1:0] SRC_SER_LO = 4'd11;
	localparam logic [SRC_W-1:0] SRC_SER_HI = 4'd14;

	// fixed priorities of the external levels
	localparam logic [PRIO_W-1:0] PRIO_EXT0 = 4'd6;
	localparam logic [PRIO_W-1:0] PRIO_EXT1 = 4'd4;
	localparam logic [PRIO_W-1:0] PRIO_EXT2 = 4'd2;

	// register file contents
	typedef struct packed {
		logic [REG_W-1:0] ctrl;
		logic [REG_W-1:0] prio_a;
		logic [REG_W-1:0] prio_b;
		logic [REG_W-1:0] prio_c;
	} cfg_regs_t;

	// one compare candidate, also the selection result
	typedef struct packed {
		logic              vld;
		logic [SRC_W-1:0]  src;
		logic [PRIO_W-1:0] prio;
		logic [CODE_W-1:0] code;
	} sel_t;

	// event code per source
	function automatic logic [CODE_W-1:0] event_code_of(input logic [SRC_W-1:0] s);
		logic [CODE_W-1:0] c;
		case (s)
			4'd0:    c = 12'h320;
			4'd1:    c = 12'h360;
			4'd2:    c = 12'h3A0;
			4'd3:    c = 12'h400;
			4'd4:    c = 12'h420;
			4'd5:    c = 12'h440;
			4'd6:    c = 12'h640;
			4'd7:    c = 12'h660;
			4'd8:    c = 12'h680;
			4'd9:    c = 12'h6A0;
			4'd10:   c = 12'h6C0;
			4'd11:   c = 12'h700;
			4'd12:   c = 12'h720;
			4'd13:   c = 12'h740;
			4'd14:   c = 12'h760;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/ips_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ips_cfg_regs
// Configuration register file: control, priority A, B and C registers.
// ----------------------------------------------------------------------------
module ips_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ips_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ips_pkg::REG_W-1:0]     cfg_data,
	output ips_pkg::cfg_regs_t            regs
);
	import ips_pkg::*;

	cfg_regs_t regs_q;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// register write, masked where the register has reserved bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_CTRL:   regs_q.ctrl   <= cfg_data & CTRL_MASK;
				REG_PRIO_A: regs_q.prio_a <= cfg_data;
				REG_PRIO_B: regs_q.prio_b <= cfg_data & PRIO_B_MASK;
				REG_PRIO_C: regs_q.prio_c <= cfg_data;
				default:    regs_q.ctrl   <= regs_q.ctrl;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ===== rtl/core/ips_select.sv =====
// ----------------------------------------------------------------------------
// ips_select
// Eligibility check and 16-leaf priority compare tree over the sources.
// ----------------------------------------------------------------------------
module ips_select (
	input  logic [ips_pkg::NUM_SRC-1:0] pending,
	input  logic [ips_pkg::SR_W-1:0]    status_word,
	input  ips_pkg::cfg_regs_t          regs,
	output ips_pkg::sel_t               result
);
	import ips_pkg::*;

	logic [PRIO_W-1:0] mask;
	logic              blocked;
	logic [15:0]       pend_leaf;
	sel_t              l0 [16];
	sel_t              l1 [8];
	sel_t              l2 [4];
	sel_t              l3 [2];
	sel_t              root;

	// priority of each source from the fixed levels and the registers
	function automatic logic [PRIO_W-1:0] prio_of(
		input logic [SRC_W-1:0] s,
		input logic [REG_W-1:0] pa,
		input logic [REG_W-1:0] pc
	);
		logic [PRIO_W-1:0] p;
		case (s) inside
			SRC_EXT0:                 p = PRIO_EXT0;
			SRC_EXT1:                 p = PRIO_EXT1;
			SRC_EXT2:                 p = PRIO_EXT2;
			SRC_TMR0:                 p = pa[15:12];
			SRC_TMR1:                 p = pa[11:8];
			SRC_TMR2:                 p = pa[7:4];
			[SRC_DMA_LO:SRC_DMA_HI]: p = pc[11:8];
			[SRC_SER_LO:SRC_SER_HI]: p = pc[7:4];
			default:                  p = '0;
		endcase
		return p;
	endfunction

	// pick b over a only on strictly higher priority, so ties keep the lower index
	function automatic sel_t pick(input sel_t a, input sel_t b);
		return (b.vld && (!a.vld || (b.prio > a.prio))) ? b : a;
	endfunction

	assign mask    = status_word[SR_MASK_LO +: PRIO_W];
	assign blocked = status_word[SR_BLOCK_BIT];

	// pending lines padded to the leaf count, the spare leaf never pending
	assign pend_leaf = {1'b0, pending};

	// leaves: one candidate per source, last leaf unused
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			l0[i].src  = SRC_W'(i);
			l0[i].prio = prio_of(SRC_W'(i), regs.prio_a, regs.prio_c);
			l0[i].code = event_code_of(SRC_W'(i));
			l0[i].vld  = pend_leaf[i] && !blocked && (l0[i].prio > mask);
		end
	end

	// compare tree
	always_comb begin
		for (int i = 0; i < 8; i++) l1[i] = pick(l0[2*i], l0[2*i+1]);
		for (int i = 0; i < 4; i++) l2[i] = pick(l1[2*i], l1[2*i+1]);
		for (int i = 0; i < 2; i++) l3[i] = pick(l2[2*i], l2[2*i+1]);
		root = pick(l3[0], l3[1]);
	end

	// zero the fields when nothing wins
	always_comb begin
		result = root.vld ? root : '0;
	end

endmodule

// ===== rtl/core/interrupt_priority_selector_unit.sv =====
// ----------------------------------------------------------------------------
// interrupt_priority_selector_unit
// Pending-line tracker with a prioritized interrupt select per item.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------
//  item     | item_valid / item_stall   | op, source_id, line_level, status_register
//  result   | result_valid / result_stall | selected_valid, selected_source,
//           |                           | event_code, selected_priority
//  cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  Two register stages: the input register, then the result register. One item
//  is taken per cycle unless a stalled result backs up both stages. The pending
//  update and the 15-way compare tree sit between the two.
//  Reset clears the pending lines, the configuration registers and both stage valids.
//  A stalled result holds; item_stall rises only when both stages are full
//  and the result is stalled.
// ----------------------------------------------------------------------------
module interrupt_priority_selector_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          op,
	input  logic [ips_pkg::SRC_W-1:0]     source_id,
	input  logic                          line_level,
	input  logic [ips_pkg::SR_W-1:0]      status_register,
	// result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          selected_valid,
	output logic [ips_pkg::SRC_W-1:0]     selected_source,
	output logic [ips_pkg::CODE_W-1:0]    event_code,
	output logic [ips_pkg::PRIO_W-1:0]    selected_priority,
	// config channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ips_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ips_pkg::REG_W-1:0]     cfg_data
);
	import ips_pkg::*;

	cfg_regs_t          regs;
	logic               vld_s1;
	logic               op_s1;
	logic [SRC_W-1:0]   src_s1;
	logic               level_s1;
	logic [SR_W-1:0]    sr_s1;
	logic               vld_s2;
	sel_t               res_s2;
	sel_t               sel;
	logic [NUM_SRC-1:0] pending_q;
	logic [NUM_SRC-1:0] upd_mask;
	logic [NUM_SRC-1:0] pending_next;
	logic               s2_load;
	logic               s1_adv;
	logic               s1_load;

	// register file
	ips_cfg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// stage flow control
	assign s2_load    = !vld_s2 || !result_stall;
	assign s1_adv     = vld_s1 && s2_load;
	assign s1_load    = !vld_s1 || s1_adv;
	assign item_stall = !s1_load;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s1_load) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && item_valid) begin
			op_s1    <= op;
			src_s1   <= source_id;
			level_s1 <= line_level;
			sr_s1    <= status_register;
		end
	end

	// pending line update; an index past the last source shifts out to nothing
	assign upd_mask     = op_s1 ? (NUM_SRC'(1) << src_s1) : '0;
	assign pending_next = level_s1 ? (pending_q | upd_mask) : (pending_q & ~upd_mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (s1_adv) begin
			pending_q <= pending_next;
		end
	end

	// selection on the updated lines
	ips_select u_select (
		.pending     (pending_next),
		.status_word (sr_s1),
		.regs        (regs),
		.result      (sel)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_load) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_s2 <= sel;
		end
	end

	assign result_valid      = vld_s2;
	assign selected_valid    = res_s2.vld;
	assign selected_source   = res_s2.src;
	assign event_code        = res_s2.code;
	assign selected_priority = res_s2.prio;

endmodule

// ===== rtl/core/ips_checker.sv =====
// ----------------------------------------------------------------------------
// ips_checker
// Port-level checks on the result channel of the selector.
// ----------------------------------------------------------------------------
module ips_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic                          selected_valid,
	input logic [ips_pkg::SRC_W-1:0]     selected_source,
	input logic [ips_pkg::CODE_W-1:0]    event_code,
	input logic [ips_pkg::PRIO_W-1:0]    selected_priority
);
	import ips_pkg::*;

	// no winner shows all-zero fields
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !selected_valid |->
			selected_source == '0 && event_code == '0 && selected_priority == '0)
		else $error("result fields not zero without a winner");

	// a winner has a non-zero priority and a real source
	a_win_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && selected_valid |->
			selected_priority != '0 && selected_source != 4'd15)
		else $error("winner with zero priority or unknown source");

	// the code matches the winning source
	a_win_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && selected_valid |->
			event_code == event_code_of(selected_source))
		else $error("event code does not match winning source");

	// a stalled result beat holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(selected_valid) && $stable(selected_source) &&
			$stable(event_code) && $stable(selected_priority))
		else $error("stalled result beat changed");

endmodule

bind interrupt_priority_selector_unit ips_checker u_ips_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.result_valid      (result_valid),
	.result_stall      (result_stall),
	.selected_valid    (selected_valid),
	.selected_source   (selected_source),
	.event_code        (event_code),
	.selected_priority (selected_priority)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for interrupt_priority_selector_unit. A queue of line
// events and status words feeds a clocked driver; a shadow of the pending
// lines and priority registers predicts each selection; a clocked monitor
// compares every result beat with the oldest prediction. Runs through several
// register settings with random gaps, stalls and two long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb;
	import ips_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 60;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 170;
	localparam int SHOW_LIMIT   = 10;

	// one line event plus status word
	typedef struct packed {
		logic              op;
		logic [SRC_W-1:0]  src;
		logic              lvl;
		logic [SR_W-1:0]   sr;
	} irq_req_t;

	// predicted selection
	typedef struct packed {
		logic              vld;
		logic [SRC_W-1:0]  src;
		logic [CODE_W-1:0] code;
		logic [PRIO_W-1:0] prio;
	} irq_grant_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	logic                 op = 1'b0;
	logic [SRC_W-1:0]     source_id = '0;
	logic                 line_level = 1'b0;
	logic [SR_W-1:0]      status_register = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic                 selected_valid;
	logic [SRC_W-1:0]     selected_source;
	logic [CODE_W-1:0]    event_code;
	logic [PRIO_W-1:0]    selected_priority;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	reg_idx_t             cfg_index = REG_CTRL;
	logic [REG_W-1:0]     cfg_data = '0;

	// shadow state of the block
	logic [NUM_SRC-1:0]   pending_lines = '0;
	logic [REG_W-1:0]     ctrl_shadow = '0;
	logic [REG_W-1:0]     prio_a_shadow = '0;
	logic [REG_W-1:0]     prio_b_shadow = '0;
	logic [REG_W-1:0]     prio_c_shadow = '0;

	irq_req_t             stim_q[$];
	irq_grant_t           grant_q[$];
	irq_req_t             next_req;
	irq_grant_t           want;

	int                   send_gap_max = 0;
	int                   recv_gap_max = 0;
	int                   send_wait = 0;
	int                   recv_wait = 0;
	int                   recv_draw;
	int                   hold_left = 0;
	bit                   hold_req = 1'b0;
	bit                   hold_seen = 1'b0;
	int                   fail_cnt = 0;
	int                   quiet_cycles = 0;

	interrupt_priority_selector_unit dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.item_valid        (item_valid),
		.item_stall        (item_stall),
		.op                (op),
		.source_id         (source_id),
		.line_level        (line_level),
		.status_register   (status_register),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.selected_valid    (selected_valid),
		.selected_source   (selected_source),
		.event_code        (event_code),
		.selected_priority (selected_priority),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// priority level of a source from the shadow registers
	function automatic logic [PRIO_W-1:0] source_level(input int s);
		case (s)
			SRC_EXT0: return PRIO_EXT0;
			SRC_EXT1: return PRIO_EXT1;
			SRC_EXT2: return PRIO_EXT2;
			SRC_TMR0: return prio_a_shadow[15:12];
			SRC_TMR1: return prio_a_shadow[11:8];
			SRC_TMR2: return prio_a_shadow[7:4];
			default:  return (s <= SRC_DMA_HI) ? prio_c_shadow[11:8] : prio_c_shadow[7:4];
		endcase
	endfunction

	// event codes step through each group from its base
	function automatic logic [CODE_W-1:0] source_code(input int s);
		if (s <= SRC_EXT2)
			return 12'h320 + 12'((s - SRC_EXT0) * 'h40);
		if (s <= SRC_TMR2)
			return 12'h400 + 12'((s - SRC_TMR0) * 'h20);
		if (s <= SRC_DMA_HI)
			return 12'h640 + 12'((s - SRC_DMA_LO) * 'h20);
		return 12'h700 + 12'((s - SRC_SER_LO) * 'h20);
	endfunction

	// highest eligible pending source, lowest index on a tie
	function automatic irq_grant_t arbitrate(input logic [SR_W-1:0] sr);
		irq_grant_t g;
		logic [PRIO_W-1:0] lv;
		logic [PRIO_W-1:0] thr;
		int i;
		g = '0;
		thr = sr[SR_MASK_LO +: PRIO_W];
		if (!sr[SR_BLOCK_BIT]) begin
			for (i = 0; i < NUM_SRC; i++) begin
				lv = source_level(i);
				if (pending_lines[i] && lv != 0 && lv > thr && (!g.vld || lv > g.prio)) begin
					g.vld  = 1'b1;
					g.src  = SRC_W'(i);
					g.prio = lv;
					g.code = source_code(i);
				end
			end
		end
		return g;
	endfunction

	// apply an accepted beat to the pending lines and queue its selection
	function automatic void take_line_event(input logic upd, input logic [SRC_W-1:0] sid,
			input logic lvl, input logic [SR_W-1:0] sr);
		if (upd && sid < NUM_SRC)
			pending_lines[sid] = lvl;
		grant_q.push_back(arbitrate(sr));
	endfunction

	function automatic void add_item(input logic o, input logic [SRC_W-1:0] s,
			input logic l, input logic [SR_W-1:0] sr);
		irq_req_t r;
		r = '{op: o, src: s, lvl: l, sr: sr};
		stim_q.push_back(r);
	endfunction

	// write all four registers, one beat each, and track them
	task automatic program_regs(input logic [REG_W-1:0] c, input logic [REG_W-1:0] a,
			input logic [REG_W-1:0] b, input logic [REG_W-1:0] p);
		logic [REG_W-1:0] vals [4];
		reg_idx_t idx;
		int k;
		vals = '{c, a, b, p};
		for (k = 0; k < 4; k++) begin
			idx = reg_idx_t'(k);
			@(posedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= vals[k];
			do @(posedge clk); while (!cfg_ready);
			cfg_valid <= 1'b0;
			case (idx)
				REG_CTRL:   ctrl_shadow   = vals[k] & CTRL_MASK;
				REG_PRIO_A: prio_a_shadow = vals[k];
				REG_PRIO_B: prio_b_shadow = vals[k] & PRIO_B_MASK;
				REG_PRIO_C: prio_c_shadow = vals[k];
				default:    ;
			endcase
		end
		@(negedge clk);
	endtask

	// everything sent and every selection back
	task automatic wait_drained();
		do @(negedge clk); while (stim_q.size() != 0 || item_valid || grant_q.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	// item driver
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_wait  <= 0;
		end else begin
			if (item_valid && !item_stall)
				take_line_event(op, source_id, line_level, status_register);
			if (!item_valid || !item_stall) begin
				if (send_wait != 0) begin
					send_wait  <= send_wait - 1;
					item_valid <= 1'b0;
				end else if (stim_q.size() != 0) begin
					next_req = stim_q.pop_front();
					op              <= next_req.op;
					source_id       <= next_req.src;
					line_level      <= next_req.lvl;
					status_register <= next_req.sr;
					item_valid      <= 1'b1;
					send_wait       <= $urandom_range(send_gap_max, 0);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			recv_wait    <= 0;
			hold_left    <= 0;
		end else begin
			// check each result beat against the oldest prediction
			if (result_valid && !result_stall) begin
				if (grant_q.size() == 0) begin
					if (fail_cnt < SHOW_LIMIT)
						$display("unexpected result beat: vld=%0d src=%0d code=%h prio=%0d",
							selected_valid, selected_source, event_code, selected_priority);
					fail_cnt++;
				end else begin
					want = grant_q.pop_front();
					if (selected_valid !== want.vld || selected_source !== want.src ||
							event_code !== want.code || selected_priority !== want.prio) begin
						if (fail_cnt < SHOW_LIMIT) begin
							$write("mismatch: exp vld=%0d src=%0d code=%h prio=%0d,",
								want.vld, want.src, want.code, want.prio);
							$display(" got vld=%0d src=%0d code=%h prio=%0d",
								selected_valid, selected_source, event_code, selected_priority);
						end
						fail_cnt++;
					end
				end
			end
			// long hold-off on request, else a drawn stall after each beat
			if (hold_left != 0) begin
				result_stall <= (hold_left != 1);
				hold_left    <= hold_left - 1;
			end else if (hold_seen != hold_req) begin
				hold_seen    <= hold_req;
				hold_left    <= HOLD_CYCLES;
				result_stall <= 1'b1;
			end else if (result_valid && !result_stall) begin
				recv_draw = $urandom_range(recv_gap_max, 0);
				recv_wait    <= recv_draw;
				result_stall <= (recv_draw != 0);
			end else if (recv_wait != 0) begin
				recv_wait    <= recv_wait - 1;
				result_stall <= (recv_wait != 1);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else if (quiet_cycles == QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus sequence
	initial begin
		irq_req_t r;
		int ph;
		int n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: timers 7/5/3, dma 10, serial 9
		send_gap_max = 3;
		recv_gap_max = 3;
		program_regs(16'hFFFF, 16'h7530, 16'hFFFF, 16'h0A90);
		add_item(1'b0, 4'd0,  1'b0, 32'h0000_0000);
		add_item(1'b1, 4'd2,  1'b1, 32'h0000_0000);
		add_item(1'b1, 4'd1,  1'b1, 32'h0000_0000);
		add_item(1'b1, 4'd5,  1'b1, 32'h0000_0000);
		add_item(1'b1, 4'd0,  1'b1, 32'h0000_0000);
		add_item(1'b1, 4'd3,  1'b1, 32'h0000_0000);
		add_item(1'b1, 4'd4,  1'b1, 32'h0000_0000);
		add_item(1'b1, 4'd14, 1'b1, 32'h0000_0000);
		add_item(1'b1, 4'd10, 1'b1, 32'h0000_0000);
		// equal priority, lower index wins
		add_item(1'b1, 4'd6,  1'b1, 32'h0000_0000);
		// mask at its top, just below and equal to the best level
		add_item(1'b0, 4'd0,  1'b0, 32'h0000_00F0);
		add_item(1'b0, 4'd0,  1'b0, 32'h0000_0090);
		add_item(1'b0, 4'd0,  1'b0, 32'h0000_00A0);
		// block bit alone, every bit set, then all but the block bit and mask
		add_item(1'b0, 4'd0,  1'b0, 32'h1000_0000);
		add_item(1'b0, 4'd15, 1'b1, 32'hFFFF_FFFF);
		add_item(1'b0, 4'd0,  1'b0, 32'hEFFF_FF0F);
		// updates of the out-of-range source are dropped
		add_item(1'b1, 4'd15, 1'b1, 32'h0000_0000);
		add_item(1'b1, 4'd15, 1'b0, 32'h0000_0000);
		add_item(1'b1, 4'd6,  1'b0, 32'h0000_0000);
		// query only leaves the line alone
		add_item(1'b0, 4'd6,  1'b1, 32'h0000_0000);
		add_item(1'b1, 4'd10, 1'b0, 32'h0000_0000);
		add_item(1'b1, 4'd14, 1'b0, 32'h0000_0060);
		add_item(1'b1, 4'd3,  1'b0, 32'h0000_0060);
		add_item(1'b1, 4'd11, 1'b1, 32'h0000_0000);
		wait_drained();

		// random phases over a range of register settings
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph % 5)
				0: begin send_gap_max = 13; recv_gap_max = 13; end
				1: begin send_gap_max = 0;  recv_gap_max = 0;  end
				2: begin send_gap_max = 13; recv_gap_max = 0;  end
				3: begin send_gap_max = 0;  recv_gap_max = 13; end
				default: begin send_gap_max = 4; recv_gap_max = 4; end
			endcase
			case (ph)
				0: program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
				1: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: program_regs(16'h5A5A, 16'h6420, 16'hA5A5, 16'h0640);
				5: program_regs(16'h3C7F, 16'hF000, 16'hC30F, 16'h0010);
				7: program_regs(16'h0000, 16'h1230, 16'h0000, 16'h0F80);
				9: program_regs(16'hFFFF, 16'h8880, 16'hFFFF, 16'h0880);
				default: program_regs(REG_W'($urandom), REG_W'($urandom),
						REG_W'($urandom), REG_W'($urandom));
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				r.op  = ($urandom_range(3, 0) != 0);
				r.src = ($urandom_range(15, 0) == 0) ? 4'd15 : SRC_W'($urandom_range(14, 0));
				r.lvl = 1'($urandom_range(1, 0));
				r.sr  = $urandom;
				r.sr[SR_BLOCK_BIT] = ($urandom_range(7, 0) == 0);
				// keep the mask low most of the time so selections happen
				if ($urandom_range(3, 0) != 0)
					r.sr[SR_MASK_LO +: PRIO_W] = PRIO_W'($urandom_range(5, 0));
				stim_q.push_back(r);
			end
			// receiver holds off while the sender keeps offering
			if (ph == 1 || ph == 6)
				hold_req = ~hold_req;
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (fail_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/ips_pkg.sv
rtl/core/ips_cfg_regs.sv
rtl/core/ips_select.sv
rtl/core/interrupt_priority_selector_unit.sv
rtl/core/ips_checker.sv
verif/tb.sv
